// ===== src/fde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_pkg
// Shared types and constants of the packed 4bpp framebuffer draw engine.
// ----------------------------------------------------------------------------
package fde_pkg;

	// default screen size
	localparam int DEF_SCREEN_WIDTH  = 320;
	localparam int DEF_SCREEN_HEIGHT = 240;

	// coordinate and count widths
	localparam int X_W   = 10;
	localparam int Y_W   = 9;
	localparam int CNT_W = 17;

	// font store
	localparam int FONT_DEPTH = 4096;
	localparam int FONT_AW    = 12;

	// command queue depth between front and back
	localparam int QDEPTH = 2;

	// command codes
	localparam logic [2:0] MODE_PUT   = 3'd0;
	localparam logic [2:0] MODE_GET   = 3'd1;
	localparam logic [2:0] MODE_FILL  = 3'd2;
	localparam logic [2:0] MODE_GLYPH = 3'd3;
	localparam logic [2:0] MODE_LOAD  = 3'd4;

	// command class seen by the back end
	typedef enum logic [2:0] {
		K_SOLID = 3'd0,
		K_GET   = 3'd1,
		K_GLYPH = 3'd2,
		K_LOAD  = 3'd3,
		K_NOP   = 3'd4
	} kind_t;

	// classified command, one queue entry
	typedef struct packed {
		kind_t            kind;
		logic             empty;
		logic [X_W-1:0]   x0;
		logic [Y_W-1:0]   y0;
		logic [X_W-1:0]   xe;
		logic [Y_W-1:0]   ye;
		logic [3:0]       pen;
		logic [7:0]       code;
		logic [3:0]       grow;
		logic [7:0]       fbits;
		logic             dbl;
	} cmd_t;

endpackage

// ===== src/framebuffer_draw_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_core
// Drawing engine over a packed 4bpp framebuffer: put/get pixel, rectangle
// fill, 8x16 glyph at normal or double size, font byte load.
//
//   channel | signals                    | beat taken when
//   --------+----------------------------+-------------------------
//   in      | in_valid / in_ready        | in_valid && in_ready
//   out     | out_valid / out_ready      | out_valid && out_ready
//   cfg     | cfg_wr_en / cfg_wr_data    | cfg_wr_en
//
// Drawing: a put or fill scans its clipped box pixel by pixel through the
// frame store read-modify-write pipeline; a glyph also fetches one font byte
// per screen row before it scans that row; a get reads one stored pixel;
// load, unused modes and empty or off-screen commands draw nothing.
// Reset: a clearing pass zeroes all ceil(SCREEN_WIDTH/2)*SCREEN_HEIGHT bytes
// of the frame store (38400 by default); in_ready stays low meanwhile.
// Stalls: the front keeps taking beats into a two-entry queue, until it is
// full, while the back draws or holds an untaken result.
// ----------------------------------------------------------------------------
module framebuffer_draw_engine_core #(
	parameter int SCREEN_WIDTH  = fde_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = fde_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [3:0]                cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                mode,
	input  logic [8:0]                pos_x,
	input  logic [7:0]                pos_y,
	input  logic [9:0]                end_x,
	input  logic [8:0]                end_y,
	input  logic [3:0]                pen_color,
	input  logic [7:0]                char_code,
	input  logic [3:0]                glyph_row,
	input  logic [7:0]                font_bits,
	input  logic                      double_size,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [3:0]                pixel_value,
	output logic [fde_pkg::CNT_W-1:0] pixels_written
);
	import fde_pkg::*;

	cmd_t push_cmd, head_cmd;
	logic push, pop, q_full, q_nonempty, clearing;

	// classify incoming beats
	fde_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pen_color   (pen_color),
		.char_code   (char_code),
		.glyph_row   (glyph_row),
		.font_bits   (font_bits),
		.double_size (double_size),
		.q_full      (q_full),
		.clearing    (clearing),
		.push        (push),
		.cmd         (push_cmd)
	);

	// decouple front and back
	fde_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.nonempty (q_nonempty),
		.dout     (head_cmd)
	);

	// carry out commands
	fde_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.q_valid        (q_nonempty),
		.q_cmd          (head_cmd),
		.q_pop          (pop),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_value    (pixel_value),
		.pixels_written (pixels_written)
	);

endmodule

// ===== src/fde_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_front
// Accepts command beats, classifies them and clips their box to the screen.
// ----------------------------------------------------------------------------
module fde_front #(
	parameter int SCREEN_WIDTH  = fde_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = fde_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        mode,
	input  logic [8:0]        pos_x,
	input  logic [7:0]        pos_y,
	input  logic [9:0]        end_x,
	input  logic [8:0]        end_y,
	input  logic [3:0]        pen_color,
	input  logic [7:0]        char_code,
	input  logic [3:0]        glyph_row,
	input  logic [7:0]        font_bits,
	input  logic              double_size,
	input  logic              q_full,
	input  logic              clearing,
	output logic              push,
	output fde_pkg::cmd_t     cmd
);
	import fde_pkg::*;

	localparam logic [X_W-1:0] W_X = X_W'(SCREEN_WIDTH);
	localparam logic [Y_W-1:0] H_Y = Y_W'(SCREEN_HEIGHT);

	logic [X_W-1:0] x_lo, x_raw, x_end;
	logic [Y_W-1:0] y_lo, y_raw, y_end;
	kind_t          kind;

	assign x_lo = {1'b0, pos_x};
	assign y_lo = {1'b0, pos_y};

	// classify and pick the raw exclusive box ends
	always_comb begin
		kind  = K_NOP;
		x_raw = x_lo;
		y_raw = y_lo;
		case (mode)
			MODE_PUT, MODE_GET: begin
				kind  = (mode == MODE_PUT) ? K_SOLID : K_GET;
				x_raw = x_lo + X_W'(1);
				y_raw = y_lo + Y_W'(1);
			end
			MODE_FILL: begin
				kind  = K_SOLID;
				x_raw = end_x;
				y_raw = end_y;
			end
			MODE_GLYPH: begin
				kind  = K_GLYPH;
				x_raw = x_lo + (double_size ? X_W'(16) : X_W'(8));
				y_raw = y_lo + (double_size ? Y_W'(32) : Y_W'(16));
			end
			MODE_LOAD: begin
				kind = K_LOAD;
			end
			default: begin
				kind = K_NOP;
			end
		endcase
	end

	// clip to the screen
	assign x_end = (x_raw > W_X) ? W_X : x_raw;
	assign y_end = (y_raw > H_Y) ? H_Y : y_raw;

	assign in_ready = !q_full && !clearing;
	assign push     = in_valid && in_ready;

	always_comb begin
		cmd.kind  = kind;
		cmd.empty = (x_end <= x_lo) || (y_end <= y_lo);
		cmd.x0    = x_lo;
		cmd.y0    = y_lo;
		cmd.xe    = x_end;
		cmd.ye    = y_end;
		cmd.pen   = pen_color;
		cmd.code  = char_code;
		cmd.grow  = glyph_row;
		cmd.fbits = font_bits;
		cmd.dbl   = double_size;
	end

endmodule

// ===== src/fde_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_queue
// Short command queue that decouples the front end from the draw back end.
// ----------------------------------------------------------------------------
module fde_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fde_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output fde_pkg::cmd_t dout
);
	import fde_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_QW = $clog2(QDEPTH + 1);

	cmd_t              entry_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] cnt_q;

	assign full     = (cnt_q == CNT_QW'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign dout     = entry_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_QW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_QW'(1);
			end
		end
	end

	// store the entry
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== src/fde_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_back
// Draw sequencer: frame and font stores, pixel read-modify-write pipeline,
// clearing pass after reset and the result register.
// ----------------------------------------------------------------------------
module fde_back #(
	parameter int SCREEN_WIDTH  = fde_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = fde_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [3:0]                cfg_wr_data,
	input  logic                      q_valid,
	input  fde_pkg::cmd_t             q_cmd,
	output logic                      q_pop,
	output logic                      clearing,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [3:0]                pixel_value,
	output logic [fde_pkg::CNT_W-1:0] pixels_written
);
	import fde_pkg::*;

	localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
	localparam int FRAME_BYTES = ROW_BYTES * SCREEN_HEIGHT;
	localparam int ADDR_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_FONT  = 8'b0000_0100,
		ST_SCAN  = 8'b0000_1000,
		ST_DRAIN = 8'b0001_0000,
		ST_GET   = 8'b0010_0000,
		ST_GETW  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [3:0]        bg_q;
	logic [ADDR_W-1:0] clr_q;

	// current command
	kind_t             kind_q;
	logic [X_W-1:0]    x0_q, xe_q, x_q;
	logic [Y_W-1:0]    ye_q, y_q;
	logic [3:0]        dx_q;
	logic [4:0]        dy_q;
	logic              dbl_q;
	logic [3:0]        pen_q;
	logic [7:0]        code_q;
	logic [ADDR_W-1:0] row_base_q;
	logic [CNT_W-1:0]  count_q;
	logic [3:0]        val_q;

	// memories
	logic [7:0]        frame_mem [FRAME_BYTES];
	logic [7:0]        font_mem [FONT_DEPTH];
	logic [7:0]        rd_q, font_q;

	// write stage
	logic              vld_s2, odd_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [3:0]        color_s2;
	logic              last_vld_q;
	logic [ADDR_W-1:0] last_addr_q;
	logic [7:0]        last_data_q;

	logic [ADDR_W+7:0] row_prod;
	logic [2:0]        col;
	logic [3:0]        line;
	logic [3:0]        pix_color;
	logic [ADDR_W-1:0] pix_addr, get_addr, rd_addr, wr_addr;
	logic [7:0]        src_byte, merge_byte, wr_data;
	logic              wr_en, font_we, font_re, row_last, col_last;
	logic [FONT_AW-1:0] font_ra, font_wa;

	assign clearing = (state_q == ST_CLEAR);
	assign q_pop    = q_valid && (state_q == ST_IDLE);

	// row base of the popped command
	assign row_prod = (ADDR_W + 8)'(q_cmd.y0) * (ADDR_W + 8)'(ROW_BYTES);

	// glyph bit select
	assign col       = dbl_q ? dx_q[3:1] : dx_q[2:0];
	assign line      = dbl_q ? dy_q[4:1] : dy_q[3:0];
	assign pix_color = (kind_q == K_GLYPH) ? (font_q[3'd7 - col] ? pen_q : bg_q) : pen_q;
	assign pix_addr  = row_base_q + ADDR_W'(x_q[X_W-1:1]);
	assign get_addr  = row_base_q + ADDR_W'(x0_q[X_W-1:1]);
	assign rd_addr   = (state_q == ST_GET) ? get_addr : pix_addr;
	assign col_last  = (x_q + X_W'(1) == xe_q);
	assign row_last  = (y_q + Y_W'(1) == ye_q);

	// merge the nibble, forwarding the previous write to the same byte
	assign src_byte   = (last_vld_q && last_addr_q == addr_s2) ? last_data_q : rd_q;
	assign merge_byte = odd_s2 ? {src_byte[7:4], color_s2} : {color_s2, src_byte[3:0]};

	assign wr_en   = clearing || vld_s2;
	assign wr_addr = clearing ? clr_q : addr_s2;
	assign wr_data = clearing ? 8'h00 : merge_byte;

	assign font_we = q_pop && (q_cmd.kind == K_LOAD);
	assign font_wa = {q_cmd.code, q_cmd.grow};
	assign font_re = (state_q == ST_FONT);
	assign font_ra = {code_q, line};

	// frame store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= wr_data;
		end
		rd_q <= frame_mem[rd_addr];
	end

	// font store
	always_ff @(posedge clk) begin
		if (font_we) begin
			font_mem[font_wa] <= q_cmd.fbits;
		end
		if (font_re) begin
			font_q <= font_mem[font_ra];
		end
	end

	// background color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= 4'h0;
		end else if (cfg_wr_en) begin
			bg_q <= cfg_wr_data;
		end
	end

	// write stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2     <= 1'b0;
			last_vld_q <= 1'b0;
		end else begin
			vld_s2     <= (state_q == ST_SCAN);
			last_vld_q <= vld_s2;
		end
	end

	// write stage payload
	always_ff @(posedge clk) begin
		addr_s2     <= pix_addr;
		odd_s2      <= x_q[0];
		color_s2    <= pix_color;
		last_addr_q <= addr_s2;
		last_data_q <= merge_byte;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(FRAME_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						case (q_cmd.kind)
							K_SOLID:  state_q <= q_cmd.empty ? ST_DONE : ST_SCAN;
							K_GLYPH:  state_q <= q_cmd.empty ? ST_DONE : ST_FONT;
							K_GET:    state_q <= q_cmd.empty ? ST_DONE : ST_GET;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_FONT: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (col_last && row_last) begin
						state_q <= ST_DRAIN;
					end else if (col_last && kind_q == K_GLYPH) begin
						state_q <= ST_FONT;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_GET: begin
					state_q <= ST_GETW;
				end
				ST_GETW: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command and scan registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q     <= q_cmd.kind;
				x0_q       <= q_cmd.x0;
				xe_q       <= q_cmd.xe;
				ye_q       <= q_cmd.ye;
				x_q        <= q_cmd.x0;
				y_q        <= q_cmd.y0;
				dx_q       <= '0;
				dy_q       <= '0;
				dbl_q      <= q_cmd.dbl;
				pen_q      <= q_cmd.pen;
				code_q     <= q_cmd.code;
				row_base_q <= row_prod[ADDR_W-1:0];
				count_q    <= '0;
				val_q      <= 4'h0;
			end
			ST_SCAN: begin
				if (count_q != {CNT_W{1'b1}}) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (col_last) begin
					x_q        <= x0_q;
					dx_q       <= '0;
					y_q        <= y_q + Y_W'(1);
					dy_q       <= dy_q + 5'd1;
					row_base_q <= row_base_q + ADDR_W'(ROW_BYTES);
				end else begin
					x_q  <= x_q + X_W'(1);
					dx_q <= dx_q + 4'd1;
				end
			end
			ST_GETW: begin
				val_q <= x0_q[0] ? rd_q[3:0] : rd_q[7:4];
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid || out_ready)) begin
			pixel_value    <= val_q;
			pixels_written <= count_q;
		end
	end

endmodule

// ===== src/fde_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_checker
// Port-level checks of the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
module fde_checker #(
	parameter int SCREEN_WIDTH  = fde_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = fde_pkg::DEF_SCREEN_HEIGHT
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [3:0]                pixel_value,
	input logic [fde_pkg::CNT_W-1:0] pixels_written
);
	import fde_pkg::*;

	localparam int AREA = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int CAP  = (AREA < (1 << CNT_W)) ? AREA : (1 << CNT_W) - 1;

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_value)
			&& $stable(pixels_written))
		else $error("result beat changed while stalled");

	// a read never reports written pixels
	a_get_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_value != 4'h0 |-> pixels_written == '0)
		else $error("pixel value and write count both nonzero");

	// never count more pixels than the screen holds
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixels_written <= CNT_W'(CAP))
		else $error("write count exceeds screen area");

endmodule

bind framebuffer_draw_engine_core fde_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_fde_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.pixel_value    (pixel_value),
	.pixels_written (pixels_written)
);
